FILE: rtl/core/ecpm_pkg.sv
package ecpm_pkg;

    localparam int DATA_W  = 64;
    localparam int SHIFT_W = 5;
    localparam int LANES   = 4;

    // Step counter is wide enough for the 64 divide steps.
    localparam int CNT_W = 6;

    localparam int NS_PER_S_W = 30;
    localparam logic [NS_PER_S_W-1:0] NS_PER_S = 30'd1000000000;
    localparam int MW_PER_W_W = 10;
    localparam logic [MW_PER_W_W-1:0] MW_PER_W = 10'd1000;

    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd14;

    // Lane order in the power vector.
    localparam int LANE_CORE     = 0;
    localparam int LANE_GRAPHICS = 1;
    localparam int LANE_MEMORY   = 2;
    localparam int LANE_PACKAGE  = 3;

    typedef logic [DATA_W-1:0] t_word;
    typedef logic [LANES-1:0][DATA_W-1:0] t_power_vec;

    typedef struct packed {
        logic [DATA_W-1:0] core_energy;
        logic [DATA_W-1:0] graphics_energy;
        logic [DATA_W-1:0] memory_energy;
        logic [DATA_W-1:0] package_energy;
        logic [DATA_W-1:0] sample_time_ns;
    } t_req;

    typedef struct packed {
        logic [DATA_W-1:0] core_power_mw;
        logic [DATA_W-1:0] graphics_power_mw;
        logic [DATA_W-1:0] memory_power_mw;
        logic [DATA_W-1:0] package_power_mw;
        logic              fresh;
    } t_rsp;

    typedef struct packed {
        logic load;
        logic fresh;
    } t_merge_ctrl;

endpackage

FILE: rtl/core/ecpm_lane.sv
module ecpm_lane (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  ecpm_pkg::t_word              i_delta,
    input  ecpm_pkg::t_word              i_dt,
    input  logic [ecpm_pkg::SHIFT_W-1:0] i_shift,
    output logic                         o_busy,
    output ecpm_pkg::t_word              o_power
);
    import ecpm_pkg::*;

    typedef enum logic [2:0] {
        L_IDLE,
        L_MUL_NS,
        L_SHIFT,
        L_MUL_MW,
        L_DIV_SET,
        L_DIV
    } t_lane_state;

    t_lane_state       r_state;
    logic [CNT_W-1:0]  r_cnt;
    t_word             r_acc;
    t_word             r_mcand;
    t_word             r_dt;
    t_word             r_rem;
    t_word             r_q;

    logic [DATA_W:0]   rem_sh;
    logic [DATA_W:0]   rem_diff;
    logic              rem_ge;

    // One restoring divide step: bring in the next dividend bit, subtract if it fits.
    assign rem_sh   = {r_rem, r_q[DATA_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_dt};
    assign rem_ge   = ~rem_diff[DATA_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                L_IDLE: begin
                    if (i_start) begin
                        r_state <= L_MUL_NS;
                        r_cnt   <= '0;
                        r_acc   <= '0;
                        r_mcand <= i_delta;
                        r_dt    <= i_dt;
                    end
                end
                L_MUL_NS: begin
                    if (NS_PER_S[r_cnt[4:0]]) begin
                        r_acc <= r_acc + r_mcand;
                    end
                    r_mcand <= {r_mcand[DATA_W-2:0], 1'b0};
                    r_cnt   <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(NS_PER_S_W - 1)) begin
                        r_state <= L_SHIFT;
                    end
                end
                L_SHIFT: begin
                    r_mcand <= r_acc >> i_shift;
                    r_acc   <= '0;
                    r_cnt   <= '0;
                    r_state <= L_MUL_MW;
                end
                L_MUL_MW: begin
                    if (MW_PER_W[r_cnt[3:0]]) begin
                        r_acc <= r_acc + r_mcand;
                    end
                    r_mcand <= {r_mcand[DATA_W-2:0], 1'b0};
                    r_cnt   <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(MW_PER_W_W - 1)) begin
                        r_state <= L_DIV_SET;
                    end
                end
                L_DIV_SET: begin
                    r_q     <= r_acc;
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= L_DIV;
                end
                L_DIV: begin
                    r_rem <= rem_ge ? rem_diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
                    r_q   <= {r_q[DATA_W-2:0], rem_ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(DATA_W - 1)) begin
                        r_state <= L_IDLE;
                    end
                end
                default: begin
                    r_state <= L_IDLE;
                end
            endcase
        end
    end

    assign o_busy  = (r_state != L_IDLE);
    assign o_power = r_q;

endmodule

FILE: rtl/core/ecpm_merge.sv
module ecpm_merge (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ecpm_pkg::t_merge_ctrl i_ctrl,
    input  ecpm_pkg::t_power_vec  i_lane_power,
    input  logic                  i_rsp_ready,
    output logic                  o_free,
    output logic                  o_rsp_valid,
    output ecpm_pkg::t_rsp        o_rsp
);
    import ecpm_pkg::*;

    t_power_vec r_held;
    t_power_vec n_held;
    logic       r_valid;
    t_rsp       r_rsp;

    assign n_held = i_ctrl.fresh ? i_lane_power : r_held;
    assign o_free = ~r_valid | i_rsp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_held  <= '0;
        end else begin
            if (i_ctrl.load) begin
                r_valid                 <= 1'b1;
                r_held                  <= n_held;
                r_rsp.core_power_mw     <= n_held[LANE_CORE];
                r_rsp.graphics_power_mw <= n_held[LANE_GRAPHICS];
                r_rsp.memory_power_mw   <= n_held[LANE_MEMORY];
                r_rsp.package_power_mw  <= n_held[LANE_PACKAGE];
                r_rsp.fresh             <= i_ctrl.fresh;
            end else if (i_rsp_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_rsp_valid = r_valid;
    assign o_rsp       = r_rsp;

endmodule

FILE: rtl/core/energy_counter_power_meter_top.sv
// Energy counter power meter.
// A request on the input channel (i_req_valid / o_req_ready) carries four raw
// energy counter readings and a nanosecond timestamp. Each request produces
// exactly one response on the output channel (o_rsp_valid / i_rsp_ready) with
// the average power of each domain in milliwatts and a fresh flag.
// The energy unit exponent resets to 14 and is written through i_cfg_we /
// i_cfg_wdata. The user must write it only while no request is in flight;
// the block does not enforce this. A fresh request (earlier timestamp nonzero,
// time delta nonzero) starts four identical lanes, one per domain. Each lane
// multiplies by 1e9 one constant bit per cycle, shifts, multiplies by 1000 and
// then runs a one-bit-per-cycle restoring divider, the longest of these steps.
// A request that is not fresh leaves the lanes idle and is answered with the
// held powers once the output register is free. One request is in work at a
// time; the next is accepted once the response sits in the output register.
// A stalled receiver holds the response in the output register, and a
// finished computation waits in the lanes until that register frees up.
// Reset clears the previous sample, the held powers and the valid flag.
module energy_counter_power_meter_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_req_valid,
    output logic                         o_req_ready,
    input  ecpm_pkg::t_req               i_req,
    output logic                         o_rsp_valid,
    input  logic                         i_rsp_ready,
    output ecpm_pkg::t_rsp               o_rsp,
    input  logic                         i_cfg_we,
    input  logic [ecpm_pkg::SHIFT_W-1:0] i_cfg_wdata
);
    import ecpm_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_BUSY
    } t_state;

    t_state             r_state;
    logic               r_fresh;
    logic [SHIFT_W-1:0] r_shift;

    // Previous sample; a zero timestamp means there is none.
    t_word r_prev_core;
    t_word r_prev_graphics;
    t_word r_prev_memory;
    t_word r_prev_package;
    t_word r_prev_time;

    logic        req_take;
    t_word       dt;
    logic        fresh_now;
    t_power_vec  lane_delta;
    t_power_vec  lane_power;
    logic [LANES-1:0] lane_busy;
    logic        merge_free;
    t_merge_ctrl merge_ctrl;

    assign o_req_ready = (r_state == S_IDLE);
    assign req_take    = i_req_valid & o_req_ready;

    assign dt        = i_req.sample_time_ns - r_prev_time;
    assign fresh_now = (dt != '0) && (r_prev_time != '0);

    assign lane_delta[LANE_CORE]     = i_req.core_energy - r_prev_core;
    assign lane_delta[LANE_GRAPHICS] = i_req.graphics_energy - r_prev_graphics;
    assign lane_delta[LANE_MEMORY]   = i_req.memory_energy - r_prev_memory;
    assign lane_delta[LANE_PACKAGE]  = i_req.package_energy - r_prev_package;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= SHIFT_RESET;
        end else if (i_cfg_we) begin
            r_shift <= i_cfg_wdata;
        end
    end

    // The sample becomes the previous sample as soon as it is accepted; the
    // lanes have already captured their deltas by then.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_fresh         <= 1'b0;
            r_prev_core     <= '0;
            r_prev_graphics <= '0;
            r_prev_memory   <= '0;
            r_prev_package  <= '0;
            r_prev_time     <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (req_take) begin
                        r_state         <= S_BUSY;
                        r_fresh         <= fresh_now;
                        r_prev_core     <= i_req.core_energy;
                        r_prev_graphics <= i_req.graphics_energy;
                        r_prev_memory   <= i_req.memory_energy;
                        r_prev_package  <= i_req.package_energy;
                        r_prev_time     <= i_req.sample_time_ns;
                    end
                end
                S_BUSY: begin
                    if (merge_ctrl.load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    genvar g;
    generate
        for (g = 0; g < LANES; g++) begin : g_lane
            ecpm_lane u_lane (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_start (req_take & fresh_now),
                .i_delta (lane_delta[g]),
                .i_dt    (dt),
                .i_shift (r_shift),
                .o_busy  (lane_busy[g]),
                .o_power (lane_power[g])
            );
        end
    endgenerate

    // All lanes run in lock step, so the group is done when none is busy.
    assign merge_ctrl.load  = (r_state == S_BUSY) && (lane_busy == '0) && merge_free;
    assign merge_ctrl.fresh = r_fresh;

    ecpm_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (merge_ctrl),
        .i_lane_power (lane_power),
        .i_rsp_ready  (i_rsp_ready),
        .o_free       (merge_free),
        .o_rsp_valid  (o_rsp_valid),
        .o_rsp        (o_rsp)
    );

endmodule

FILE: verif/energy_counter_power_meter_top_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the energy counter power meter.
// An initial block queues up requests phase by phase and changes the energy
// unit shift between phases, only once the block has drained. A clocked driver
// feeds the queued requests onto the request channel, and a clocked monitor
// predicts every accepted request and checks every accepted response.
module energy_counter_power_meter_top_tb;

    import ecpm_pkg::*;

    localparam t_word WORD_MAX = {DATA_W{1'b1}};

    logic                i_clk;
    logic                i_rst_n;
    logic                i_req_valid;
    logic                o_req_ready;
    t_req                i_req;
    logic                o_rsp_valid;
    logic                i_rsp_ready;
    t_rsp                o_rsp;
    logic                i_cfg_we;
    logic [SHIFT_W-1:0]  i_cfg_wdata;

    energy_counter_power_meter_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Requests waiting to be driven, and responses predicted but not yet seen.
    t_req pending_reqs[$];
    t_rsp expected_rsps[$];

    int error_count = 0;

    // Percentage of cycles in which the sender holds back a new request and
    // in which the receiver drops its ready.
    int req_gap_pct   = 0;
    int rsp_stall_pct = 0;

    // Set at the rising edge at which a request was taken, so that the driver
    // knows at the following falling edge that it may present the next one.
    logic req_fire;

    // Predictor state: the previous sample, the held powers and the shift.
    t_word              last_energy [LANES];
    t_word              pred_prev_time;
    t_word              held_mw [LANES];
    logic [SHIFT_W-1:0] unit_shift;

    // Generator state, so that random requests can continue a plausible
    // stream of rising counters and timestamps.
    t_word gen_energy [LANES];
    t_word gen_time_ns;

    always #5 i_clk = ~i_clk;

    // Average power of one domain in milliwatts. Every step is done at 64 bits
    // so that products and differences wrap just as the hardware does.
    function automatic t_word domain_mw(t_word cur, t_word prev, t_word dt,
                                        logic [SHIFT_W-1:0] shift);
        t_word delta;
        t_word scaled;
        delta  = cur - prev;
        scaled = (delta * t_word'(NS_PER_S)) >> shift;
        return (scaled * t_word'(MW_PER_W)) / dt;
    endfunction

    // Works out the response to one sample and moves the predictor state on.
    function automatic t_rsp predict_power(t_req s);
        t_word dt;
        t_word cur [LANES];
        logic  is_fresh;
        t_rsp  r;
        cur[LANE_CORE]     = s.core_energy;
        cur[LANE_GRAPHICS] = s.graphics_energy;
        cur[LANE_MEMORY]   = s.memory_energy;
        cur[LANE_PACKAGE]  = s.package_energy;
        dt       = s.sample_time_ns - pred_prev_time;
        is_fresh = (dt != 0) && (pred_prev_time != 0);
        for (int i = 0; i < LANES; i++) begin
            if (is_fresh) begin
                held_mw[i] = domain_mw(cur[i], last_energy[i], dt, unit_shift);
            end
            last_energy[i] = cur[i];
        end
        pred_prev_time      = s.sample_time_ns;
        r.core_power_mw     = held_mw[LANE_CORE];
        r.graphics_power_mw = held_mw[LANE_GRAPHICS];
        r.memory_power_mw   = held_mw[LANE_MEMORY];
        r.package_power_mw  = held_mw[LANE_PACKAGE];
        r.fresh             = is_fresh;
        return r;
    endfunction

    task automatic compare_field(string name, t_word exp_val, t_word act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_val, act_val);
            error_count++;
        end
    endtask

    // Driver. Everything changes at the falling edge, one assignment per
    // signal, so a request that follows straight on keeps valid high.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_req_valid <= 1'b0;
            i_rsp_ready <= 1'b0;
        end else begin
            i_rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
            if (!i_req_valid || req_fire) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= req_gap_pct) begin
                    i_req       <= pending_reqs.pop_front();
                    i_req_valid <= 1'b1;
                end else begin
                    i_req_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor. The response is checked before the prediction of a request
    // taken at the same edge, since it can only belong to an older request.
    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            req_fire      <= 1'b0;
            pred_prev_time = '0;
            unit_shift     = SHIFT_RESET;
            for (int i = 0; i < LANES; i++) begin
                last_energy[i] = '0;
                held_mw[i]     = '0;
            end
        end else begin
            req_fire <= i_req_valid && o_req_ready;
            if (o_rsp_valid && i_rsp_ready) begin
                if (expected_rsps.size() == 0) begin
                    $display("%0t: response with none expected, actual %0h", $time, o_rsp);
                    error_count++;
                end else begin
                    want = expected_rsps.pop_front();
                    compare_field("core_power_mw", want.core_power_mw, o_rsp.core_power_mw);
                    compare_field("graphics_power_mw", want.graphics_power_mw,
                                  o_rsp.graphics_power_mw);
                    compare_field("memory_power_mw", want.memory_power_mw,
                                  o_rsp.memory_power_mw);
                    compare_field("package_power_mw", want.package_power_mw,
                                  o_rsp.package_power_mw);
                    compare_field("fresh", t_word'(want.fresh), t_word'(o_rsp.fresh));
                end
            end
            if (i_req_valid && o_req_ready) begin
                expected_rsps.push_back(predict_power(i_req));
            end
            if (i_cfg_we) begin
                unit_shift = i_cfg_wdata;
            end
        end
    end

    function automatic t_word rand_word();
        return {$urandom, $urandom};
    endfunction

    task automatic push_req(t_word core, t_word gfx, t_word mem, t_word pkg, t_word t_ns);
        t_req s;
        s.core_energy     = core;
        s.graphics_energy = gfx;
        s.memory_energy   = mem;
        s.package_energy  = pkg;
        s.sample_time_ns  = t_ns;
        pending_reqs.push_back(s);
        gen_energy[LANE_CORE]     = core;
        gen_energy[LANE_GRAPHICS] = gfx;
        gen_energy[LANE_MEMORY]   = mem;
        gen_energy[LANE_PACKAGE]  = pkg;
        gen_time_ns               = t_ns;
    endtask

    // Mostly a well-formed stream of rising counters and timestamps, with
    // repeated, zero and backward timestamps and fully random samples mixed in.
    task automatic push_random_reqs(int count);
        t_word e [LANES];
        t_word t_ns;
        int    kind;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(99);
            t_ns = gen_time_ns;
            for (int i = 0; i < LANES; i++) begin
                e[i] = gen_energy[i];
            end
            if (kind < 70) begin
                // Normal update period; now and then a long one or a big jump.
                t_ns += ($urandom_range(9) == 0) ? t_word'($urandom)
                                                 : t_word'($urandom_range(2000000, 1));
                for (int i = 0; i < LANES; i++) begin
                    e[i] += ($urandom_range(9) == 0) ? t_word'($urandom)
                                                     : t_word'($urandom_range(1 << 20));
                end
            end else if (kind < 78) begin
                // Same timestamp again: the held powers come back.
                for (int i = 0; i < LANES; i++) begin
                    e[i] += t_word'($urandom_range(1 << 16));
                end
            end else if (kind < 83) begin
                t_ns = '0;
            end else if (kind < 88) begin
                t_ns -= t_word'($urandom_range(1000000, 1));
            end else begin
                t_ns = rand_word();
                for (int i = 0; i < LANES; i++) begin
                    e[i] = rand_word();
                end
            end
            push_req(e[LANE_CORE], e[LANE_GRAPHICS], e[LANE_MEMORY], e[LANE_PACKAGE], t_ns);
        end
    endtask

    // Returns once every queued request has been driven and answered.
    task automatic wait_drained();
        @(posedge i_clk);
        while (pending_reqs.size() != 0 || i_req_valid || expected_rsps.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Writes the shift register while the block is idle.
    task automatic set_unit_shift(logic [SHIFT_W-1:0] value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_req_valid = 1'b0;
        i_rsp_ready = 1'b0;
        i_req       = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed requests at the reset shift of 14.
        req_gap_pct   = 16;
        rsp_stall_pct = 70;
        // The first sample has no previous sample to work from.
        push_req(64'd100, 64'd200, 64'd300, 64'd400, 64'd1000);
        push_req(64'd1100, 64'd1700, 64'd1300, 64'd90400, 64'd2000);
        // A zero time delta repeats the held powers.
        push_req(64'd5000, 64'd5000, 64'd5000, 64'd5000, 64'd2000);
        // A zero timestamp is still stored, so the sample after it sees none.
        push_req(64'd6000, 64'd7000, 64'd8000, 64'd9000, 64'd0);
        push_req(64'd7000, 64'd8000, 64'd9000, 64'd10000, 64'd5000);
        // Counters jump to the top and then wrap around to zero.
        push_req(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, 64'd6000);
        push_req(64'd0, 64'd0, 64'd0, 64'd0, 64'd7000);
        // Time runs backwards and then wraps past its top.
        push_req(64'd1000, 64'd1000, 64'd1000, 64'd1000, 64'd100);
        push_req(64'd2000, 64'd3000, 64'd4000, 64'd5000, WORD_MAX);
        push_req(64'd2100, 64'd3200, 64'd4300, 64'd5400, 64'd1);
        // Large deltas overflow the products.
        push_req(64'h8000_0000_0000_0000, 64'h4000_0000_0000_0000,
                 64'h0000_0001_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 64'd2);
        // A delta of one nanosecond.
        push_req(64'h8000_0000_0000_0007, 64'h4000_0000_0000_0100,
                 64'h0000_0001_0000_0001, 64'h7FFF_FFFF_FFFF_FFFF, 64'd3);
        push_req(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        push_req(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        push_req(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
        push_req(64'd0, 64'd0, 64'd0, 64'd0, 64'd0);
        push_req(64'd1, 64'd2, 64'd3, 64'd4, 64'd1);
        // One, two, a half and four joules over a millisecond at the reset shift.
        push_req(64'd16385, 64'd32770, 64'd8195, 64'd65540, 64'd1000001);

        // Random phases across the range of the shift.
        set_unit_shift(5'd0);
        push_random_reqs(100);

        set_unit_shift(5'd31);
        req_gap_pct   = 70;
        rsp_stall_pct = 16;
        push_random_reqs(100);

        set_unit_shift(SHIFT_W'($urandom_range(30, 1)));
        push_random_reqs(100);

        set_unit_shift(SHIFT_RESET);
        req_gap_pct   = 0;
        rsp_stall_pct = 0;
        push_random_reqs(150);

        // Let the last response settle, with room for a stray extra one.
        wait_drained();
        repeat (120) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog: far longer than the slowest correct run can take.
    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
